// File: design/psp_pkg.sv
`default_nettype none

package psp_pkg;

  // Configuration of the datapath
  localparam int CORDIC_STAGES = 16;
  localparam int SUM_BITS      = 25;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STG_IDX_W     = 5;

  // Angle units: 1/64 degree
  localparam int HALF_TURN_DEG = 180;
  localparam int UNITS_PER_DEG = 64;
  localparam int FULL_TURN     = 2 * HALF_TURN_DEG * UNITS_PER_DEG;
  localparam int QUARTER_TURN  = FULL_TURN / 4;

  // Field and internal widths
  localparam int MAG_W  = 16;
  localparam int ANG_W  = 16;
  localparam int RED_W  = $clog2(FULL_TURN);
  localparam int RES_W  = $clog2(QUARTER_TURN);
  localparam int QUAD_W = 2;

  // CORDIC vectors carry 30 guard bits below the magnitude LSB
  localparam int FRAC_GUARD = 30;
  localparam int VEC_W      = MAG_W + FRAC_GUARD + 2;
  localparam int TERM_W     = VEC_W - FRAC_GUARD;
  localparam int Z_W        = 32;
  localparam int Z_SHIFT    = 16;
  localparam int GAIN_W     = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;

  // Quadrant boundaries of the reduced angle
  localparam logic [RED_W-1:0] QBND_1 = RED_W'(QUARTER_TURN);
  localparam logic [RED_W-1:0] QBND_2 = RED_W'(2 * QUARTER_TURN);
  localparam logic [RED_W-1:0] QBND_3 = RED_W'(3 * QUARTER_TURN);

  // Quadrant codes
  localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int Q_IDX_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [QUAD_W-1:0] quad;
    logic [RES_W-1:0]  res;
    logic              last;
  } psp_item_t;

  // atan(2^-i) in degrees, scaled by 2^22
  function automatic logic signed [Z_W-1:0] atan_val(input logic [STG_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/psp_front.sv
`default_nettype none

module psp_front import psp_pkg::*; (
  input  wire logic [MAG_W-1:0]        in_magnitude,
  input  wire logic signed [ANG_W-1:0] in_angle,
  input  wire logic                    in_last_term,
  output psp_item_t                    item
);

  logic signed [ANG_W:0] ang_ext;
  logic signed [ANG_W:0] red;
  logic [RED_W-1:0]      red_u;

  // Reduce the angle to one full turn
  always_comb begin
    ang_ext = {in_angle[ANG_W-1], in_angle};
    if (ang_ext < 0) begin
      if (ang_ext < -FULL_TURN) begin
        red = (ANG_W+1)'(ang_ext + 2 * FULL_TURN);
      end else begin
        red = (ANG_W+1)'(ang_ext + FULL_TURN);
      end
    end else if (ang_ext >= FULL_TURN) begin
      red = (ANG_W+1)'(ang_ext - FULL_TURN);
    end else begin
      red = ang_ext;
    end
    red_u = red[RED_W-1:0];
  end

  // Split into quadrant and residual angle
  always_comb begin
    item.mag  = in_magnitude;
    item.last = in_last_term;
    if (red_u >= QBND_3) begin
      item.quad = QUAD_3;
      item.res  = RES_W'(red_u - QBND_3);
    end else if (red_u >= QBND_2) begin
      item.quad = QUAD_2;
      item.res  = RES_W'(red_u - QBND_2);
    end else if (red_u >= QBND_1) begin
      item.quad = QUAD_1;
      item.res  = RES_W'(red_u - QBND_1);
    end else begin
      item.quad = QUAD_0;
      item.res  = RES_W'(red_u);
    end
  end

endmodule

`default_nettype wire

// File: design/psp_queue.sv
`default_nettype none

module psp_queue import psp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire psp_item_t  wr_item,
  input  wire logic       rd_en,
  output psp_item_t       rd_item,
  output logic            full,
  output logic            empty,
  output logic [Q_CNT_W-1:0] count
);

  psp_item_t            mem_r [QDEPTH];
  logic [Q_IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_item = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: design/psp_back.sv
`default_nettype none

module psp_back import psp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire psp_item_t              q_item,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [SUM_BITS-1:0]  out_sum_x,
  output logic signed [SUM_BITS-1:0]  out_sum_y,
  output logic                        out_saturated
);

  localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [VEC_W-1:0]    RND_HALF = VEC_W'(1) <<< (FRAC_GUARD - 1);

  logic adv;

  // CORDIC stage registers; index 0 is the scaled start vector
  logic signed [VEC_W-1:0] x_r    [NUM_STAGES+1];
  logic signed [VEC_W-1:0] y_r    [NUM_STAGES+1];
  logic signed [Z_W-1:0]   z_r    [NUM_STAGES+1];
  logic [QUAD_W-1:0]       quad_r [NUM_STAGES+1];
  logic                    last_r [NUM_STAGES+1];
  logic                    vld_r  [NUM_STAGES+1];

  logic signed [VEC_W-1:0] x_nxt [NUM_STAGES+1];
  logic signed [VEC_W-1:0] y_nxt [NUM_STAGES+1];
  logic signed [Z_W-1:0]   z_nxt [NUM_STAGES+1];

  logic [MAG_W+GAIN_W-1:0] prod;

  logic signed [VEC_W-1:0]  rx, ry, rx_h, ry_h;
  logic signed [TERM_W-1:0] tx_nxt, ty_nxt, tx_r, ty_r;
  logic                     rvld_r, rlast_r;

  logic signed [SUM_BITS-1:0] acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  logic                       clip_r, clip_nxt;
  logic signed [SUM_BITS:0]   sum_x, sum_y;
  logic                       ovf_x, ovf_y;

  logic signed [SUM_BITS-1:0] out_sum_x_r, out_sum_y_r;
  logic                       out_sat_r, out_valid_r;

  // Whole back pipeline moves unless a result waits at a stalled output
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  // Scale the magnitude by the gain compensation
  assign prod     = q_item.mag * GAIN_Q30;
  assign x_nxt[0] = VEC_W'(prod);
  assign y_nxt[0] = '0;
  assign z_nxt[0] = Z_W'({q_item.res, {Z_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= x_nxt[0];
      y_r[0]    <= y_nxt[0];
      z_r[0]    <= z_nxt[0];
      quad_r[0] <= q_item.quad;
      last_r[0] <= q_item.last;
    end
  end

  // One CORDIC micro-rotation per stage
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]   at;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = atan_val(STG_IDX_W'(i));

    always_comb begin
      if (!z_r[i][Z_W-1]) begin
        x_nxt[i+1] = x_r[i] - dx;
        y_nxt[i+1] = y_r[i] + dy;
        z_nxt[i+1] = z_r[i] - at;
      end else begin
        x_nxt[i+1] = x_r[i] + dx;
        y_nxt[i+1] = y_r[i] - dy;
        z_nxt[i+1] = z_r[i] + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]    <= x_nxt[i+1];
        y_r[i+1]    <= y_nxt[i+1];
        z_r[i+1]    <= z_nxt[i+1];
        quad_r[i+1] <= quad_r[i];
        last_r[i+1] <= last_r[i];
      end
    end
  end

  // Map back to the quadrant and round to the magnitude LSB
  always_comb begin
    case (quad_r[NUM_STAGES])
      QUAD_1: begin
        rx = -y_r[NUM_STAGES];
        ry = x_r[NUM_STAGES];
      end
      QUAD_2: begin
        rx = -x_r[NUM_STAGES];
        ry = -y_r[NUM_STAGES];
      end
      QUAD_3: begin
        rx = y_r[NUM_STAGES];
        ry = -x_r[NUM_STAGES];
      end
      default: begin
        rx = x_r[NUM_STAGES];
        ry = y_r[NUM_STAGES];
      end
    endcase
    rx_h   = rx + RND_HALF;
    ry_h   = ry + RND_HALF;
    tx_nxt = rx_h[VEC_W-1:FRAC_GUARD];
    ty_nxt = ry_h[VEC_W-1:FRAC_GUARD];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (adv) begin
      rvld_r <= vld_r[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      rlast_r <= last_r[NUM_STAGES];
    end
  end

  // Saturating accumulation
  always_comb begin
    sum_x = {acc_x_r[SUM_BITS-1], acc_x_r}
          + {{(SUM_BITS+1-TERM_W){tx_r[TERM_W-1]}}, tx_r};
    sum_y = {acc_y_r[SUM_BITS-1], acc_y_r}
          + {{(SUM_BITS+1-TERM_W){ty_r[TERM_W-1]}}, ty_r};
    ovf_x = sum_x[SUM_BITS] ^ sum_x[SUM_BITS-1];
    ovf_y = sum_y[SUM_BITS] ^ sum_y[SUM_BITS-1];
    if (ovf_x) begin
      acc_x_nxt = sum_x[SUM_BITS] ? SUM_LO : SUM_HI;
    end else begin
      acc_x_nxt = sum_x[SUM_BITS-1:0];
    end
    if (ovf_y) begin
      acc_y_nxt = sum_y[SUM_BITS] ? SUM_LO : SUM_HI;
    end else begin
      acc_y_nxt = sum_y[SUM_BITS-1:0];
    end
    clip_nxt = clip_r || ovf_x || ovf_y;
  end

  // Update sums; on the last term load the output and clear the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rvld_r && rlast_r;
      if (rvld_r) begin
        if (rlast_r) begin
          acc_x_r <= '0;
          acc_y_r <= '0;
          clip_r  <= 1'b0;
        end else begin
          acc_x_r <= acc_x_nxt;
          acc_y_r <= acc_y_nxt;
          clip_r  <= clip_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rvld_r && rlast_r) begin
      out_sum_x_r <= acc_x_nxt;
      out_sum_y_r <= acc_y_nxt;
      out_sat_r   <= clip_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sum_x     = out_sum_x_r;
  assign out_sum_y     = out_sum_y_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// File: design/phasor_sum_polar_to_rect.sv
`default_nettype none

// Phasor sum, polar to rectangular. Each input transfer carries a magnitude
// (unsigned, 4 fraction bits), an angle in 1/64 degree and a last-term flag.
// The front reduces the angle to a quadrant and residual and writes the term
// into a 4-entry queue; the back runs a 16-stage unrolled CORDIC pipeline,
// a quadrant/rounding stage and a saturating accumulator. One term is
// accepted per cycle while the queue has room; in_stall rises only when the
// queue is full. From the queue a term passes the start-vector register, the
// CORDIC stage registers and the rounding register into the sums, and the
// sums of a run are loaded into the output register at the same edge as its
// last term. The back pipeline moves as a whole and halts only while a
// finished result sits in the output register under out_stall. saturated
// reports whether either sum clipped at any term of the run.
module phasor_sum_polar_to_rect import psp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [MAG_W-1:0]       in_magnitude,
  input  wire logic signed [ANG_W-1:0] in_angle,
  input  wire logic                   in_last_term,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [SUM_BITS-1:0]  out_sum_x,
  output logic signed [SUM_BITS-1:0]  out_sum_y,
  output logic                        out_saturated
);

  psp_item_t          f_item;
  psp_item_t          q_item;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic [Q_CNT_W-1:0] q_count;
  logic               q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the incoming term
  psp_front u_front (
    .in_magnitude (in_magnitude),
    .in_angle     (in_angle),
    .in_last_term (in_last_term),
    .item         (f_item)
  );

  // Decouple front and back
  psp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (f_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  // Rotate, round and accumulate
  psp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_item),
    .q_valid       (!q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sum_x     (out_sum_x),
    .out_sum_y     (out_sum_y),
    .out_saturated (out_saturated)
  );

  // Queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(QDEPTH))
    else $error("queue occupancy beyond depth");

  // Stall only rises after a transfer filled the queue
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("stall rose without an incoming transfer");

  // Reset leaves no result pending
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
